FILE: sv/i2cw_pkg.sv
// shared types and constants of the i2c master write engine
`default_nettype none

package i2cw_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned HALF_W      = 16;
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;

    localparam logic [HALF_W-1:0] HALF_RESET      = 16'd100;
    localparam logic [7:0]        ADDR_WRITE_MASK = 8'hFE;
    localparam logic              REG_HALF_PERIOD = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_BIT_LOW   = 3'd2,
        PH_BIT_HIGH  = 3'd3,
        PH_ACK_LOW   = 3'd4,
        PH_ACK_HIGH  = 3'd5,
        PH_STOP_LOW  = 3'd6,
        PH_STOP_HIGH = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_NACK = 2'd2
    } status_t;

    typedef struct packed {
        logic       go;
        logic [6:0] target_addr;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic       scl_in;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       data_request;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } out_item_t;

endpackage

`default_nettype wire

FILE: sv/i2cw_front.sv
// input queue that decouples transaction acceptance from the bus sequencer
`default_nettype none

module i2cw_front #(
    parameter int unsigned DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire i2cw_pkg::in_item_t in_data,
    output logic                    item_valid,
    output i2cw_pkg::in_item_t      item_data,
    input  wire logic               item_take
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    i2cw_pkg::in_item_t q_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               push, pop;

    assign in_stall   = (cnt_reg == CNT_W'(DEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item_data  = q_reg[rd_ptr_reg];
    assign push       = in_valid && !in_stall;
    assign pop        = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/i2cw_seq.sv
// bus sequencer: one tick per queued item, result held in an output register
`default_nettype none

module i2cw_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [i2cw_pkg::HALF_W-1:0] half_period,
    input  wire logic                        item_valid,
    input  wire i2cw_pkg::in_item_t          item_data,
    output logic                             item_take,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output i2cw_pkg::out_item_t              out_data
);

    localparam int unsigned HW = i2cw_pkg::HALF_W;

    i2cw_pkg::phase_t    phase_reg, phase_next;
    logic [HW-1:0]       tick_count_reg, tick_count_next;
    logic [2:0]          bit_index_reg, bit_index_next;
    logic [7:0]          shift_byte_reg, shift_byte_next;
    logic [8:0]          bytes_left_reg, bytes_left_next;
    i2cw_pkg::status_t   status_reg, status_next;
    logic                out_valid_reg;
    i2cw_pkg::out_item_t out_data_reg;
    i2cw_pkg::out_item_t result;

    logic          fire;
    logic [HW:0]   half_len, tick_inc;
    logic          count_end, high_end, sampling, cur_bit;
    logic          arb_lost, bus_free, start_ok;
    logic [8:0]    bytes_dec;
    logic          more;
    i2cw_pkg::status_t status_ack;

    assign fire      = item_valid && (!out_valid_reg || !out_stall);
    assign item_take = fire;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // shared tick conditions
    always_comb
    begin
        half_len   = (half_period == '0) ? (HW+1)'(1) : {1'b0, half_period};
        tick_inc   = {1'b0, tick_count_reg} + (HW+1)'(1);
        count_end  = (tick_inc >= half_len);
        high_end   = item_data.scl_in && count_end;
        sampling   = (tick_count_reg == '0) && item_data.scl_in;
        cur_bit    = shift_byte_reg[bit_index_reg];
        arb_lost   = sampling && (item_data.sda_in != cur_bit);
        bus_free   = item_data.scl_in && item_data.sda_in;
        start_ok   = item_data.go && bus_free;
        status_ack = (sampling && item_data.sda_in) ? i2cw_pkg::ST_NACK : status_reg;
        bytes_dec  = (bytes_left_reg != '0) ? bytes_left_reg - 9'd1 : '0;
        more       = (status_ack == i2cw_pkg::ST_OK) && (bytes_dec != '0);
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            i2cw_pkg::PH_IDLE:
            begin
                if (start_ok)
                begin
                    phase_next = i2cw_pkg::PH_START;
                end
            end
            i2cw_pkg::PH_START:
            begin
                if (count_end)
                begin
                    phase_next = i2cw_pkg::PH_BIT_LOW;
                end
            end
            i2cw_pkg::PH_BIT_LOW:
            begin
                if (count_end)
                begin
                    phase_next = i2cw_pkg::PH_BIT_HIGH;
                end
            end
            i2cw_pkg::PH_BIT_HIGH:
            begin
                if (arb_lost)
                begin
                    phase_next = i2cw_pkg::PH_IDLE;
                end
                else if (high_end)
                begin
                    phase_next = (bit_index_reg == '0) ? i2cw_pkg::PH_ACK_LOW
                                                       : i2cw_pkg::PH_BIT_LOW;
                end
            end
            i2cw_pkg::PH_ACK_LOW:
            begin
                if (count_end)
                begin
                    phase_next = i2cw_pkg::PH_ACK_HIGH;
                end
            end
            i2cw_pkg::PH_ACK_HIGH:
            begin
                if (high_end)
                begin
                    phase_next = more ? i2cw_pkg::PH_BIT_LOW : i2cw_pkg::PH_STOP_LOW;
                end
            end
            i2cw_pkg::PH_STOP_LOW:
            begin
                if (count_end)
                begin
                    phase_next = i2cw_pkg::PH_STOP_HIGH;
                end
            end
            i2cw_pkg::PH_STOP_HIGH:
            begin
                if (high_end)
                begin
                    phase_next = i2cw_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = i2cw_pkg::PH_IDLE;
            end
        endcase
    end

    // datapath state
    always_comb
    begin
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        bytes_left_next = bytes_left_reg;
        status_next     = status_reg;
        unique case (phase_reg)
            i2cw_pkg::PH_IDLE:
            begin
                if (start_ok)
                begin
                    tick_count_next = '0;
                    bit_index_next  = 3'd7;
                    shift_byte_next = {item_data.target_addr, 1'b0}
                                      & i2cw_pkg::ADDR_WRITE_MASK;
                    bytes_left_next = {1'b0, item_data.byte_count} + 9'd1;
                    status_next     = i2cw_pkg::ST_OK;
                end
                else if (item_data.go)
                begin
                    status_next = i2cw_pkg::ST_BUSY;
                end
            end
            i2cw_pkg::PH_START, i2cw_pkg::PH_BIT_LOW,
            i2cw_pkg::PH_ACK_LOW, i2cw_pkg::PH_STOP_LOW:
            begin
                tick_count_next = count_end ? '0 : tick_inc[HW-1:0];
            end
            i2cw_pkg::PH_BIT_HIGH:
            begin
                if (arb_lost)
                begin
                    tick_count_next = '0;
                    status_next     = i2cw_pkg::ST_BUSY;
                end
                else if (item_data.scl_in)
                begin
                    tick_count_next = count_end ? '0 : tick_inc[HW-1:0];
                    if (count_end && (bit_index_reg != '0))
                    begin
                        bit_index_next = bit_index_reg - 3'd1;
                    end
                end
            end
            i2cw_pkg::PH_ACK_HIGH:
            begin
                status_next = status_ack;
                if (item_data.scl_in)
                begin
                    tick_count_next = count_end ? '0 : tick_inc[HW-1:0];
                end
                if (high_end)
                begin
                    bytes_left_next = bytes_dec;
                    if (more)
                    begin
                        shift_byte_next = item_data.data_byte;
                        bit_index_next  = 3'd7;
                    end
                end
            end
            i2cw_pkg::PH_STOP_HIGH:
            begin
                if (item_data.scl_in)
                begin
                    tick_count_next = count_end ? '0 : tick_inc[HW-1:0];
                end
            end
            default:
            begin
                tick_count_next = tick_count_reg;
            end
        endcase
    end

    // result of this tick
    always_comb
    begin
        result              = '0;
        result.scl_out      = 1'b1;
        result.sda_out      = 1'b1;
        result.busy_res     = 1'b1;
        result.status       = i2cw_pkg::ST_OK;
        unique case (phase_reg)
            i2cw_pkg::PH_IDLE:
            begin
                result.busy_res = 1'b0;
                if (item_data.go && !bus_free)
                begin
                    result.done_res = 1'b1;
                    result.status   = i2cw_pkg::ST_BUSY;
                end
            end
            i2cw_pkg::PH_START:
            begin
                result.sda_out = 1'b0;
            end
            i2cw_pkg::PH_BIT_LOW:
            begin
                result.scl_out = 1'b0;
                result.sda_out = cur_bit;
            end
            i2cw_pkg::PH_BIT_HIGH:
            begin
                result.sda_out = cur_bit;
                if (arb_lost)
                begin
                    result.done_res = 1'b1;
                    result.status   = i2cw_pkg::ST_BUSY;
                end
            end
            i2cw_pkg::PH_ACK_LOW:
            begin
                result.scl_out = 1'b0;
            end
            i2cw_pkg::PH_ACK_HIGH:
            begin
                result.data_request = high_end && more;
            end
            i2cw_pkg::PH_STOP_LOW:
            begin
                result.scl_out = 1'b0;
                result.sda_out = 1'b0;
            end
            i2cw_pkg::PH_STOP_HIGH:
            begin
                result.sda_out = 1'b0;
                if (high_end)
                begin
                    result.done_res = 1'b1;
                    result.status   = status_reg;
                end
            end
            default:
            begin
                result.busy_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2cw_pkg::PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            bytes_left_reg <= '0;
            status_reg     <= i2cw_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg      <= phase_next;
                tick_count_reg <= tick_count_next;
                bit_index_reg  <= bit_index_next;
                shift_byte_reg <= shift_byte_next;
                bytes_left_reg <= bytes_left_next;
                status_reg     <= status_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

FILE: sv/i2c_master_write_engine.sv
// top level of the i2c master write engine: register port, input queue, sequencer
// path of a transaction: it is written into the input queue, and its result is then
// registered in the sequencer output register before it is offered
// throughput without stalls: one input transaction and one sequencer tick per cycle
// a stalled output holds its result while the input queue takes transactions until full
// reset: phase idle, counters and status cleared, queue empty, half period 100 ticks
`default_nettype none

module i2c_master_write_engine #(
    parameter int unsigned QUEUE_DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input transactions, one per bus tick
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire i2cw_pkg::in_item_t            in_data,
    // result transactions, one per bus tick
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output i2cw_pkg::out_item_t                out_data,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [i2cw_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [i2cw_pkg::PDATA_W-1:0]  pwdata,
    output logic [i2cw_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int unsigned HW = i2cw_pkg::HALF_W;

    // half period register, used by the sequencer from the next tick on
    logic [HW-1:0]      half_period_reg, half_period_next;
    logic               reg_sel;
    logic               cfg_write;

    // queue to sequencer
    logic               item_valid;
    i2cw_pkg::in_item_t item_data;
    logic               item_take;

    // word index from the upper address bit; only the first word holds a register
    assign reg_sel   = (paddr[2] == i2cw_pkg::REG_HALF_PERIOD);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign prdata    = reg_sel ? {{(i2cw_pkg::PDATA_W - HW){1'b0}}, half_period_reg} : '0;

    always_comb
    begin
        half_period_next = half_period_reg;
        if (cfg_write)
        begin
            half_period_next = pwdata[HW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= i2cw_pkg::HALF_RESET;
        end
        else
        begin
            half_period_reg <= half_period_next;
        end
    end

    // front: takes input transactions into a short queue
    i2cw_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_data  (item_data),
        .item_take  (item_take)
    );

    // back: runs the bus phases and registers each tick's result
    i2cw_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_period (half_period_reg),
        .item_valid  (item_valid),
        .item_data   (item_data),
        .item_take   (item_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

FILE: sv/i2cw_checker.sv
// port-level checks of the i2c master write engine and their binding
`default_nettype none

module i2cw_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire i2cw_pkg::out_item_t out_data
);

    // status only carries meaning on the finishing tick
    a_status_only_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.done_res |-> out_data.status == i2cw_pkg::ST_OK)
        else $error("status set outside a finishing tick");

    // an idle engine leaves both lines released
    a_idle_releases_bus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.busy_res |-> out_data.scl_out && out_data.sda_out)
        else $error("bus driven while idle");

    // a data byte is only fetched at the end of an acknowledge high half
    a_request_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.data_request |-> out_data.busy_res && !out_data.done_res
            && out_data.scl_out && out_data.sda_out)
        else $error("data request outside an active transfer");

    // a clean finish comes only out of the stop phase
    a_ok_finish_from_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res && out_data.status == i2cw_pkg::ST_OK
            |-> out_data.busy_res && out_data.scl_out && !out_data.sda_out)
        else $error("ok finish outside stop");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind i2c_master_write_engine i2cw_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
